@@ hdl/assert_macros.svh @@
// assertion helpers used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DDO_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ddo_pkg.sv @@
package ddo_pkg;

   // datapath operation codes
   localparam logic [4:0] OP_NOP   = 5'd0;
   localparam logic [4:0] OP_LOAD  = 5'd1;
   localparam logic [4:0] OP_BASE  = 5'd2;
   localparam logic [4:0] OP_DL    = 5'd3;
   localparam logic [4:0] OP_DR    = 5'd4;
   localparam logic [4:0] OP_SUM   = 5'd5;
   localparam logic [4:0] OP_YA    = 5'd6;
   localparam logic [4:0] OP_BLO   = 5'd7;
   localparam logic [4:0] OP_BHI   = 5'd8;
   localparam logic [4:0] OP_ANG   = 5'd9;
   localparam logic [4:0] OP_CMID  = 5'd10;
   localparam logic [4:0] OP_CSTEP = 5'd11;
   localparam logic [4:0] OP_CEND  = 5'd12;
   localparam logic [4:0] OP_PX    = 5'd13;
   localparam logic [4:0] OP_PY    = 5'd14;
   localparam logic [4:0] OP_POSE  = 5'd15;
   localparam logic [4:0] OP_NLO   = 5'd16;
   localparam logic [4:0] OP_NHI   = 5'd17;
   localparam logic [4:0] OP_DINIT = 5'd18;
   localparam logic [4:0] OP_DSTEP = 5'd19;
   localparam logic [4:0] OP_DEND  = 5'd20;
   localparam logic [4:0] OP_CHALF = 5'd21;
   localparam logic [4:0] OP_OUT   = 5'd22;

   // register indexes
   localparam logic [3:0] REG_WHEEL_RADIUS = 4'd0;
   localparam logic [3:0] REG_INV_TRACK    = 4'd1;

   localparam logic [19:0] RADIUS_RST    = 20'd6554;
   localparam logic [23:0] INV_TRACK_RST = 24'd131072;

   // arithmetic constants
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [29:0] INV_TWO_PI_Q32     = 30'd683565276;
   localparam logic [29:0] NS_PER_S           = 30'd1000000000;

   // last divider step index: quotient bits 95 down to 25 or 24
   localparam logic [6:0] DIV_LAST_LIN = 7'd70;
   localparam logic [6:0] DIV_LAST_ANG = 7'd71;

   typedef struct packed {
      logic [4:0] op;
      logic [6:0] step;
      logic       lane;
   } ddo_cmd_type;

   typedef struct packed {
      logic have_base;
      logic dt_pos;
      logic out_full;
   } ddo_sts_type;

   typedef struct packed {
      logic               format_ok;
      logic signed [31:0] left_angle;
      logic signed [31:0] right_angle;
      logic [62:0]        stamp_ns;
      logic [62:0]        arrival_ns;
   } ddo_req_type;

   typedef struct packed {
      logic [62:0]        out_stamp_ns;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading_angle;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] linear_velocity;
      logic signed [31:0] angular_velocity;
   } ddo_rsp_type;

   // arctangent of 2^-i as binary angle
   function automatic logic [30:0] atan_bam(input logic [4:0] idx);
      logic [30:0] v;
      unique case (idx)
         5'd0:  v = 31'd536870912;
         5'd1:  v = 31'd316933406;
         5'd2:  v = 31'd167458907;
         5'd3:  v = 31'd85004756;
         5'd4:  v = 31'd42667331;
         5'd5:  v = 31'd21354465;
         5'd6:  v = 31'd10679838;
         5'd7:  v = 31'd5340245;
         5'd8:  v = 31'd2670163;
         5'd9:  v = 31'd1335087;
         5'd10: v = 31'd667544;
         5'd11: v = 31'd333772;
         5'd12: v = 31'd166886;
         5'd13: v = 31'd83443;
         5'd14: v = 31'd41722;
         5'd15: v = 31'd20861;
         5'd16: v = 31'd10430;
         5'd17: v = 31'd5215;
         5'd18: v = 31'd2608;
         5'd19: v = 31'd1304;
         5'd20: v = 31'd652;
         5'd21: v = 31'd326;
         5'd22: v = 31'd163;
         5'd23: v = 31'd81;
         5'd24: v = 31'd41;
         5'd25: v = 31'd20;
         5'd26: v = 31'd10;
         5'd27: v = 31'd5;
         5'd28: v = 31'd3;
         5'd29: v = 31'd1;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/ddo_intf.sv @@
interface ddo_req_if;
   logic               valid;
   logic               ready;
   logic               format_ok;
   logic signed [31:0] left_angle;
   logic signed [31:0] right_angle;
   logic [62:0]        stamp_ns;
   logic [62:0]        arrival_ns;
   modport source (output valid, format_ok, left_angle, right_angle, stamp_ns, arrival_ns,
                   input ready);
   modport sink (input valid, format_ok, left_angle, right_angle, stamp_ns, arrival_ns,
                 output ready);
endinterface

interface ddo_rsp_if;
   logic               valid;
   logic               ready;
   logic [62:0]        out_stamp_ns;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] heading_angle;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   logic signed [31:0] linear_velocity;
   logic signed [31:0] angular_velocity;
   modport source (output valid, out_stamp_ns, pos_x, pos_y, heading_angle, quat_z, quat_w,
                   linear_velocity, angular_velocity, input ready);
   modport sink (input valid, out_stamp_ns, pos_x, pos_y, heading_angle, quat_z, quat_w,
                 linear_velocity, angular_velocity, output ready);
endinterface

interface ddo_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/ddo_ctrl.sv @@
module ddo_ctrl import ddo_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_format_ok,
   output logic        req_ready,
   input  ddo_sts_type sts,
   output ddo_cmd_type cmd
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_CHK   = 5'd1;
   localparam logic [4:0] ST_DR    = 5'd2;
   localparam logic [4:0] ST_SUM   = 5'd3;
   localparam logic [4:0] ST_YA    = 5'd4;
   localparam logic [4:0] ST_BLO   = 5'd5;
   localparam logic [4:0] ST_BHI   = 5'd6;
   localparam logic [4:0] ST_ANG   = 5'd7;
   localparam logic [4:0] ST_CI1   = 5'd8;
   localparam logic [4:0] ST_CS1   = 5'd9;
   localparam logic [4:0] ST_CE1   = 5'd10;
   localparam logic [4:0] ST_PX    = 5'd11;
   localparam logic [4:0] ST_PY    = 5'd12;
   localparam logic [4:0] ST_POSE  = 5'd13;
   localparam logic [4:0] ST_VCHK  = 5'd14;
   localparam logic [4:0] ST_NLO   = 5'd15;
   localparam logic [4:0] ST_NHI   = 5'd16;
   localparam logic [4:0] ST_DINIT = 5'd17;
   localparam logic [4:0] ST_DSTEP = 5'd18;
   localparam logic [4:0] ST_DEND  = 5'd19;
   localparam logic [4:0] ST_CI2   = 5'd20;
   localparam logic [4:0] ST_CS2   = 5'd21;
   localparam logic [4:0] ST_CE2   = 5'd22;
   localparam logic [4:0] ST_OUT   = 5'd23;

   localparam logic [6:0] CORDIC_LAST = 7'(CORDIC_STAGES - 1);

   logic [4:0] state_ff, state_in;
   logic [6:0] step_ff, step_in;
   logic       lane_ff, lane_in;

   // next state and command decode
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      lane_in   = lane_ff;
      cmd.op    = OP_NOP;
      cmd.step  = step_ff;
      cmd.lane  = lane_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_format_ok) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (sts.have_base) begin
               cmd.op   = OP_DL;
               state_in = ST_DR;
            end else begin
               cmd.op   = OP_BASE;
               state_in = ST_IDLE;
            end
         end
         ST_DR: begin
            cmd.op   = OP_DR;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            state_in = ST_YA;
         end
         ST_YA: begin
            cmd.op   = OP_YA;
            state_in = ST_BLO;
         end
         ST_BLO: begin
            cmd.op   = OP_BLO;
            state_in = ST_BHI;
         end
         ST_BHI: begin
            cmd.op   = OP_BHI;
            state_in = ST_ANG;
         end
         ST_ANG: begin
            cmd.op   = OP_ANG;
            state_in = ST_CI1;
         end
         ST_CI1: begin
            cmd.op   = OP_CMID;
            step_in  = '0;
            state_in = ST_CS1;
         end
         ST_CS1: begin
            cmd.op = OP_CSTEP;
            if (step_ff == CORDIC_LAST) begin
               step_in  = '0;
               state_in = ST_CE1;
            end else begin
               step_in = step_ff + 7'd1;
            end
         end
         ST_CE1: begin
            cmd.op   = OP_CEND;
            state_in = ST_PX;
         end
         ST_PX: begin
            cmd.op   = OP_PX;
            state_in = ST_PY;
         end
         ST_PY: begin
            cmd.op   = OP_PY;
            state_in = ST_POSE;
         end
         ST_POSE: begin
            cmd.op   = OP_POSE;
            state_in = ST_VCHK;
         end
         ST_VCHK: begin
            lane_in  = 1'b0;
            state_in = sts.dt_pos ? ST_NLO : ST_CI2;
         end
         ST_NLO: begin
            cmd.op   = OP_NLO;
            state_in = ST_NHI;
         end
         ST_NHI: begin
            cmd.op   = OP_NHI;
            state_in = ST_DINIT;
         end
         ST_DINIT: begin
            cmd.op   = OP_DINIT;
            step_in  = '0;
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.op = OP_DSTEP;
            if (step_ff == (lane_ff ? DIV_LAST_ANG : DIV_LAST_LIN)) begin
               step_in  = '0;
               state_in = ST_DEND;
            end else begin
               step_in = step_ff + 7'd1;
            end
         end
         ST_DEND: begin
            cmd.op = OP_DEND;
            if (lane_ff) begin
               state_in = ST_CI2;
            end else begin
               lane_in  = 1'b1;
               state_in = ST_NLO;
            end
         end
         ST_CI2: begin
            cmd.op   = OP_CHALF;
            step_in  = '0;
            state_in = ST_CS2;
         end
         ST_CS2: begin
            cmd.op = OP_CSTEP;
            if (step_ff == CORDIC_LAST) begin
               step_in  = '0;
               state_in = ST_CE2;
            end else begin
               step_in = step_ff + 7'd1;
            end
         end
         ST_CE2: begin
            cmd.op   = OP_CEND;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (!sts.out_full) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         lane_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         lane_ff  <= lane_in;
      end
   end

endmodule

@@ hdl/ddo_datapath.sv @@
module ddo_datapath import ddo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ddo_cmd_type cmd,
   input  ddo_req_type req,
   input  logic        csr_write,
   input  logic [3:0]  csr_index,
   input  logic [23:0] csr_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output ddo_rsp_type rsp,
   output ddo_sts_type sts
);

   localparam logic signed [72:0] ROUND_HALF = 73'sd8589934592;
   localparam logic signed [39:0] SAT_HI     = 40'sd2147483647;
   localparam logic signed [39:0] SAT_LO     = -40'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   // round half up to q1.15 and saturate
   function automatic logic signed [15:0] q15(input logic signed [32:0] v);
      logic signed [33:0] r;
      logic signed [18:0] s;
      logic signed [15:0] o;
      r = 34'(v) + 34'sd16384;
      s = 19'(r >>> 15);
      if (s > 19'sd32767) begin
         o = 16'sh7fff;
      end else if (s < -19'sd32768) begin
         o = 16'sh8000;
      end else begin
         o = 16'(s);
      end
      return o;
   endfunction

   // configuration and architectural state
   logic [19:0]        radius_ff;
   logic [23:0]        itw_ff;
   logic               have_base_ff;
   logic signed [31:0] last_left_ff, last_right_ff;
   logic [62:0]        last_stamp_ff;
   logic signed [31:0] pose_x_ff, pose_y_ff;
   logic [31:0]        heading_ff;

   // working registers
   logic signed [31:0] in_left_ff, in_right_ff;
   logic [62:0]        stamp_ff;
   logic signed [72:0] prod_ff;
   logic signed [54:0] dl_ff, sum2_ff, diff_ff;
   logic               yneg_ff;
   logic [60:0]        ya_ff, blo_ff, nlo_ff;
   logic [31:0]        bam_ff, half_ff;
   logic signed [32:0] cx_ff, cy_ff, cz_ff, c_ff, s_ff;
   logic               flip_ff;
   logic [62:0]        dt_ff;
   logic               dt_pos_ff;
   logic signed [31:0] lin_ff, ang_ff;
   logic [95:0]        num_ff;
   logic [63:0]        rem_ff;
   logic [32:0]        quo_ff;
   logic               sticky_ff;
   ddo_rsp_type        rsp_ff;
   logic               rsp_valid_ff;

   // combinational helpers
   logic signed [38:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [32:0] dla, dra;
   logic [54:0]        mag_diff, mag_sum;
   logic [60:0]        vel_mag;
   logic signed [33:0] p_dist;
   logic signed [54:0] prod55, diff_c;
   logic [73:0]        ang_acc;
   logic [31:0]        bam_c, half_c, cor_angle, cor_rot;
   logic               cor_flip;
   logic [4:0]         cidx;
   logic signed [32:0] cdx, cdy, catan;
   logic signed [72:0] rnd_sum;
   logic signed [38:0] pose_step;
   logic [63:0]        div_r2;
   logic               div_ge;
   logic               vel_big, vel_neg;
   logic [31:0]        vel_q;
   logic signed [31:0] vel_val;

   assign dla      = 33'(in_left_ff) - 33'(last_left_ff);
   assign dra      = 33'(in_right_ff) - 33'(last_right_ff);
   assign mag_diff = diff_ff[54] ? 55'(-diff_ff) : 55'(diff_ff);
   assign mag_sum  = sum2_ff[54] ? 55'(-sum2_ff) : 55'(sum2_ff);
   assign vel_mag  = cmd.lane ? ya_ff : 61'(mag_sum);
   assign p_dist   = 34'(sum2_ff >>> 21);
   assign prod55   = 55'(prod_ff);
   assign diff_c   = prod55 - dl_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_DL: begin
            mul_a = 39'(dla);
            mul_b = 34'(radius_ff);
         end
         OP_DR: begin
            mul_a = 39'(dra);
            mul_b = 34'(radius_ff);
         end
         OP_YA: begin
            mul_a = 39'(mag_diff[52:16]);
            mul_b = 34'(itw_ff);
         end
         OP_BLO: begin
            mul_a = 39'(prod_ff[30:0]);
            mul_b = 34'(INV_TWO_PI_Q32);
         end
         OP_BHI: begin
            mul_a = 39'(ya_ff[60:31]);
            mul_b = 34'(INV_TWO_PI_Q32);
         end
         OP_PX: begin
            mul_a = 39'(p_dist);
            mul_b = 34'(c_ff);
         end
         OP_PY: begin
            mul_a = 39'(p_dist);
            mul_b = 34'(s_ff);
         end
         OP_NLO: begin
            mul_a = 39'(vel_mag[30:0]);
            mul_b = 34'(NS_PER_S);
         end
         OP_NHI: begin
            mul_a = 39'(vel_mag[60:31]);
            mul_b = 34'(NS_PER_S);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // yaw change to binary angle, full and half
   assign ang_acc = 74'(blo_ff) + {prod_ff[42:0], 31'b0};
   assign bam_c   = yneg_ff ? 32'(-ang_acc[71:40]) : ang_acc[71:40];
   assign half_c  = yneg_ff ? 32'(-ang_acc[72:41]) : ang_acc[72:41];

   // cordic start angle folded into the right half plane
   assign cor_angle = (cmd.op == OP_CHALF) ? {heading_ff[31], heading_ff[31:1]}
                                           : heading_ff + half_ff;
   assign cor_flip  = cor_angle[31] ^ cor_angle[30];
   assign cor_rot   = {cor_angle[31] ^ cor_flip, cor_angle[30:0]};

   // cordic rotation step
   assign cidx  = cmd.step[4:0];
   assign cdx   = cy_ff >>> cidx;
   assign cdy   = cx_ff >>> cidx;
   assign catan = signed'(33'(atan_bam(cidx)));

   // position increment, rounded half up
   assign rnd_sum   = prod_ff + ROUND_HALF;
   assign pose_step = 39'(rnd_sum >>> 34);

   // restoring divider step
   assign div_r2 = {rem_ff[62:0], num_ff[95]};
   assign div_ge = div_r2 >= {1'b0, dt_ff};

   // velocity clamp and sign
   assign vel_big = sticky_ff || (quo_ff > 33'h080000000);
   assign vel_q   = vel_big ? 32'h80000000 : quo_ff[31:0];
   assign vel_neg = cmd.lane ? yneg_ff : sum2_ff[54];
   assign vel_val = vel_neg ? signed'(32'(-vel_q))
                            : (vel_q[31] ? 32'sh7fffffff : signed'(vel_q));

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RST;
         itw_ff        <= INV_TRACK_RST;
         have_base_ff  <= 1'b0;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         last_stamp_ff <= '0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         heading_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == REG_WHEEL_RADIUS) begin
               radius_ff <= csr_data[19:0];
            end else if (csr_index == REG_INV_TRACK) begin
               itw_ff <= csr_data;
            end
         end
         // response valid: set by a new result, cleared when taken
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_BASE: begin
               last_left_ff  <= in_left_ff;
               last_right_ff <= in_right_ff;
               last_stamp_ff <= stamp_ff;
               have_base_ff  <= 1'b1;
            end
            OP_PY: begin
               pose_x_ff <= sat32(40'(pose_x_ff) + 40'(pose_step));
            end
            OP_POSE: begin
               pose_y_ff  <= sat32(40'(pose_y_ff) + 40'(pose_step));
               heading_ff <= heading_ff + bam_ff;
            end
            OP_OUT: begin
               last_left_ff  <= in_left_ff;
               last_right_ff <= in_right_ff;
               last_stamp_ff <= stamp_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      prod_ff <= 73'(mul_a) * 73'(mul_b);
      unique case (cmd.op)
         OP_LOAD: begin
            in_left_ff  <= req.left_angle;
            in_right_ff <= req.right_angle;
            stamp_ff    <= (req.stamp_ns == '0) ? req.arrival_ns : req.stamp_ns;
         end
         OP_DR: begin
            dl_ff <= prod55;
         end
         OP_SUM: begin
            sum2_ff <= dl_ff + prod55;
            diff_ff <= diff_c;
            yneg_ff <= diff_c[54];
         end
         OP_BLO: begin
            ya_ff <= prod_ff[60:0];
         end
         OP_BHI: begin
            blo_ff <= prod_ff[60:0];
         end
         OP_ANG: begin
            bam_ff  <= bam_c;
            half_ff <= half_c;
         end
         OP_CMID, OP_CHALF: begin
            cx_ff   <= CORDIC_GAIN;
            cy_ff   <= '0;
            cz_ff   <= 33'(signed'(cor_rot));
            flip_ff <= cor_flip;
         end
         OP_CSTEP: begin
            if (!cz_ff[32]) begin
               cx_ff <= cx_ff - cdx;
               cy_ff <= cy_ff + cdy;
               cz_ff <= cz_ff - catan;
            end else begin
               cx_ff <= cx_ff + cdx;
               cy_ff <= cy_ff - cdy;
               cz_ff <= cz_ff + catan;
            end
         end
         OP_CEND: begin
            c_ff <= flip_ff ? -cx_ff : cx_ff;
            s_ff <= flip_ff ? -cy_ff : cy_ff;
         end
         OP_POSE: begin
            dt_ff     <= stamp_ff - last_stamp_ff;
            dt_pos_ff <= stamp_ff > last_stamp_ff;
            lin_ff    <= '0;
            ang_ff    <= '0;
         end
         OP_NHI: begin
            nlo_ff <= prod_ff[60:0];
         end
         OP_DINIT: begin
            num_ff    <= 96'(nlo_ff) + {prod_ff[64:0], 31'b0};
            rem_ff    <= '0;
            quo_ff    <= '0;
            sticky_ff <= 1'b0;
         end
         OP_DSTEP: begin
            rem_ff    <= div_ge ? div_r2 - {1'b0, dt_ff} : div_r2;
            num_ff    <= {num_ff[94:0], 1'b0};
            sticky_ff <= sticky_ff | quo_ff[32];
            quo_ff    <= {quo_ff[31:0], div_ge};
         end
         OP_DEND: begin
            if (cmd.lane) begin
               ang_ff <= vel_val;
            end else begin
               lin_ff <= vel_val;
            end
         end
         OP_OUT: begin
            rsp_ff.out_stamp_ns     <= stamp_ff;
            rsp_ff.pos_x            <= pose_x_ff;
            rsp_ff.pos_y            <= pose_y_ff;
            rsp_ff.heading_angle    <= signed'(heading_ff);
            rsp_ff.quat_z           <= q15(s_ff);
            rsp_ff.quat_w           <= q15(c_ff);
            rsp_ff.linear_velocity  <= lin_ff;
            rsp_ff.angular_velocity <= ang_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;
   assign sts.have_base = have_base_ff;
   assign sts.dt_pos    = dt_pos_ff;
   assign sts.out_full  = rsp_valid_ff && !rsp_ready;

endmodule

@@ hdl/differential_drive_odometry_top.sv @@
// channel   dir  handshake      payload
// req_ch    in   valid/ready    format_ok, wheel angles, stamp, arrival time
// rsp_ch    out  valid/ready    stamp, pose, heading, quaternion, velocities
// csr_ch    in   valid/ready    register index, write data (always ready)
//
// a good request after the baseline runs the bit-serial divider (one quotient
// bit a cycle, 71 and 72 bits) only when the interval is positive; otherwise
// it goes straight from the pose update to the second cordic pass.
// reset is synchronous; the result waits in an output register, and a stalled
// rsp_ch only holds the next result back when it is ready to leave.
`include "assert_macros.svh"

module differential_drive_odometry_top import ddo_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input logic        clock,
   input logic        reset,
   ddo_req_if.sink    req_ch,
   ddo_rsp_if.source  rsp_ch,
   ddo_csr_if.sink    csr_ch
);

   ddo_cmd_type cmd;
   ddo_sts_type sts;
   ddo_req_type req_pl;
   ddo_rsp_type rsp_pl;
   logic        req_ready;
   logic        rsp_valid;

   // request payload
   assign req_pl.format_ok   = req_ch.format_ok;
   assign req_pl.left_angle  = req_ch.left_angle;
   assign req_pl.right_angle = req_ch.right_angle;
   assign req_pl.stamp_ns    = req_ch.stamp_ns;
   assign req_pl.arrival_ns  = req_ch.arrival_ns;
   assign req_ch.ready       = req_ready;
   assign csr_ch.ready       = 1'b1;

   ddo_ctrl #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_format_ok(req_ch.format_ok),
      .req_ready    (req_ready),
      .sts          (sts),
      .cmd          (cmd)
   );

   ddo_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req      (req_pl),
      .csr_write(csr_ch.valid),
      .csr_index(csr_ch.index),
      .csr_data (csr_ch.data),
      .rsp_ready(rsp_ch.ready),
      .rsp_valid(rsp_valid),
      .rsp      (rsp_pl),
      .sts      (sts)
   );

   // response payload
   assign rsp_ch.valid            = rsp_valid;
   assign rsp_ch.out_stamp_ns     = rsp_pl.out_stamp_ns;
   assign rsp_ch.pos_x            = rsp_pl.pos_x;
   assign rsp_ch.pos_y            = rsp_pl.pos_y;
   assign rsp_ch.heading_angle    = rsp_pl.heading_angle;
   assign rsp_ch.quat_z           = rsp_pl.quat_z;
   assign rsp_ch.quat_w           = rsp_pl.quat_w;
   assign rsp_ch.linear_velocity  = rsp_pl.linear_velocity;
   assign rsp_ch.angular_velocity = rsp_pl.angular_velocity;

   // checks
   `DDO_ASSERT(a_out_free, clock, reset, cmd.op == OP_OUT, !(rsp_ch.valid && !rsp_ch.ready), "result overwrites a pending response")
   `DDO_ASSERT(a_div_dt, clock, reset, cmd.op == OP_DSTEP, sts.dt_pos, "divider runs without a positive interval")
   `DDO_ASSERT_NXT(a_load_next, clock, reset, cmd.op == OP_LOAD, (cmd.op == OP_DL || cmd.op == OP_BASE), "load not followed by delta or baseline")

endmodule
